/* rtl/core/moesif_line_coherence_controller_top_macros.svh */
// Assertion helpers shared by the coherence controller RTL.
`ifndef MOESIF_LINE_COHERENCE_CONTROLLER_TOP_MACROS_SVH
`define MOESIF_LINE_COHERENCE_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("coherence controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define MLCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("coherence controller check failed");

`endif

/* rtl/core/moesif_lcc_pkg.sv */
package moesif_lcc_pkg;

   localparam int ADDR_WIDTH_DEFAULT = 32;
   localparam int ID_WIDTH_DEFAULT = 4;
   localparam int STATE_WIDTH = 4;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_I  = 4'd0,
      ST_S  = 4'd1,
      ST_E  = 4'd2,
      ST_O  = 4'd3,
      ST_M  = 4'd4,
      ST_F  = 4'd5,
      ST_IS = 4'd6,
      ST_IM = 4'd7,
      ST_SM = 4'd8,
      ST_OM = 4'd9,
      ST_FM = 4'd10
   } state_type;

   typedef enum logic [1:0] {
      REQ_NONE = 2'd0,
      REQ_GETS = 2'd1,
      REQ_GETM = 2'd2
   } bus_req_type;

   typedef enum logic [1:0] {
      ERR_OK          = 2'd0,
      ERR_OUTSTANDING = 2'd1,
      ERR_DATA        = 2'd2,
      ERR_ILLEGAL     = 2'd3
   } err_type;

   localparam logic MODE_PROC  = 1'b0;
   localparam logic MODE_SNOOP = 1'b1;

   localparam logic [1:0] MSG_LOAD  = 2'd0;
   localparam logic [1:0] MSG_STORE = 2'd1;
   localparam logic [1:0] SNP_GETS  = 2'd0;
   localparam logic [1:0] SNP_GETM  = 2'd1;
   localparam logic [1:0] SNP_DATA  = 2'd2;

   typedef struct packed {
      bus_req_type bus_request;
      logic        data_to_proc;
      logic        data_on_bus;
      logic        miss;
      logic        silent_upgrade;
      logic        cache_transfer;
      err_type     error_code;
      state_type   state_next;
   } result_type;

endpackage

/* rtl/core/moesif_lcc_next.sv */
module moesif_lcc_next
   import moesif_lcc_pkg::*;
(
   input  state_type  state_cur,
   input  logic       mode,
   input  logic [1:0] message,
   input  logic       shared_line,
   output result_type res
);

   logic transient;
   logic getm;

   assign transient = (state_cur == ST_IS) || (state_cur == ST_IM) || (state_cur == ST_SM) ||
                      (state_cur == ST_OM) || (state_cur == ST_FM);
   assign getm = (message == SNP_GETM);

   always_comb begin
      res = '{bus_request: REQ_NONE, data_to_proc: 1'b0, data_on_bus: 1'b0, miss: 1'b0,
              silent_upgrade: 1'b0, cache_transfer: 1'b0, error_code: ERR_OK,
              state_next: state_cur};
      if (mode == MODE_PROC) begin
         if ((message != MSG_LOAD) && (message != MSG_STORE)) begin
            res.error_code = ERR_ILLEGAL;
         end else if (transient) begin
            res.error_code = ERR_OUTSTANDING;
         end else if (message == MSG_LOAD) begin
            if (state_cur == ST_I) begin
               res.bus_request = REQ_GETS;
               res.state_next = ST_IS;
               res.miss = 1'b1;
            end else begin
               res.data_to_proc = 1'b1;
            end
         end else begin
            case (state_cur)
               ST_I: begin
                  res.bus_request = REQ_GETM;
                  res.state_next = ST_IM;
                  res.miss = 1'b1;
               end
               ST_S: begin
                  res.bus_request = REQ_GETM;
                  res.state_next = ST_SM;
                  res.miss = 1'b1;
               end
               ST_O: begin
                  res.bus_request = REQ_GETM;
                  res.state_next = ST_OM;
                  res.miss = 1'b1;
               end
               ST_F: begin
                  res.bus_request = REQ_GETM;
                  res.state_next = ST_FM;
                  res.miss = 1'b1;
               end
               ST_E: begin
                  res.data_to_proc = 1'b1;
                  res.state_next = ST_M;
                  res.silent_upgrade = 1'b1;
               end
               default: begin
                  res.data_to_proc = 1'b1;
               end
            endcase
         end
      end else if ((message != SNP_GETS) && (message != SNP_GETM) &&
                   (message != SNP_DATA)) begin
         res.error_code = ERR_ILLEGAL;
      end else if (message == SNP_DATA) begin
         case (state_cur)
            ST_I: begin
               res.state_next = ST_I;
            end
            ST_IS: begin
               res.data_to_proc = 1'b1;
               res.state_next = shared_line ? ST_S : ST_E;
            end
            ST_IM, ST_SM, ST_OM, ST_FM: begin
               res.data_to_proc = 1'b1;
               res.state_next = ST_M;
            end
            default: begin
               res.error_code = ERR_DATA;
            end
         endcase
      end else begin
         case (state_cur)
            ST_S: begin
               if (getm) begin
                  res.state_next = ST_I;
               end
            end
            ST_E: begin
               res.data_on_bus = 1'b1;
               res.state_next = getm ? ST_I : ST_F;
            end
            ST_M: begin
               res.data_on_bus = 1'b1;
               res.state_next = getm ? ST_I : ST_O;
            end
            ST_O, ST_F: begin
               res.data_on_bus = 1'b1;
               if (getm) begin
                  res.state_next = ST_I;
               end
            end
            ST_OM, ST_FM: begin
               res.data_on_bus = 1'b1;
               if (getm) begin
                  res.state_next = ST_IM;
               end
            end
            default: begin
               res.state_next = state_cur;
            end
         endcase
         res.cache_transfer = res.data_on_bus;
      end
   end

endmodule

/* rtl/core/moesif_line_coherence_controller_top.sv */
// An accepted item waits in the input register; its result is then registered in the result register.
// Throughput: one item per cycle unless a result is stalled; one line-state lookup and update.
// An input register and a result register let one item wait while its result is stalled.
// Reset is synchronous and active high; it returns the line to state I and empties both stages.
// Results appear in acceptance order, one per item.
module moesif_line_coherence_controller_top
   import moesif_lcc_pkg::*;
#(
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT,
   parameter int ID_WIDTH   = ID_WIDTH_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [1:0]             req_message,
   input  logic                   req_shared_line,
   input  logic [ADDR_WIDTH-1:0]  req_line_address,
   input  logic [ID_WIDTH-1:0]    req_requester_id,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_bus_request,
   output logic                   rsp_data_to_proc,
   output logic                   rsp_data_on_bus,
   output logic [ID_WIDTH-1:0]    rsp_data_destination,
   output logic [ADDR_WIDTH-1:0]  rsp_result_address,
   output logic                   rsp_miss,
   output logic                   rsp_silent_upgrade,
   output logic                   rsp_cache_transfer,
   output logic [1:0]             rsp_error_code,
   output logic [STATE_WIDTH-1:0] rsp_state_now
);

`include "moesif_line_coherence_controller_top_macros.svh"

   logic                  in_valid_ff, in_valid_in;
   logic                  in_mode_ff;
   logic [1:0]            in_message_ff;
   logic                  in_shared_ff;
   logic [ADDR_WIDTH-1:0] in_addr_ff;
   logic [ID_WIDTH-1:0]   in_rid_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_res_ff;
   logic [ID_WIDTH-1:0]   rsp_dest_ff;
   logic [ADDR_WIDTH-1:0] rsp_addr_ff;

   state_type             state_ff, state_in;
   result_type            step_res;
   logic                  advance;
   logic                  take_in;
   logic                  fire;

   moesif_lcc_next u_next (
      .state_cur   (state_ff),
      .mode        (in_mode_ff),
      .message     (in_message_ff),
      .shared_line (in_shared_ff),
      .res         (step_res)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;
   assign fire      = in_valid_ff && advance;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      state_in     = fire ? step_res.state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_I;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         in_mode_ff    <= req_mode;
         in_message_ff <= req_message;
         in_shared_ff  <= req_shared_line;
         in_addr_ff    <= req_line_address;
         in_rid_ff     <= req_requester_id;
      end
      if (fire) begin
         rsp_res_ff  <= step_res;
         rsp_dest_ff <= step_res.data_on_bus ? in_rid_ff : '0;
         rsp_addr_ff <= in_addr_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_bus_request      = rsp_res_ff.bus_request;
   assign rsp_data_to_proc     = rsp_res_ff.data_to_proc;
   assign rsp_data_on_bus      = rsp_res_ff.data_on_bus;
   assign rsp_data_destination = rsp_dest_ff;
   assign rsp_result_address   = rsp_addr_ff;
   assign rsp_miss             = rsp_res_ff.miss;
   assign rsp_silent_upgrade   = rsp_res_ff.silent_upgrade;
   assign rsp_cache_transfer   = rsp_res_ff.cache_transfer;
   assign rsp_error_code       = rsp_res_ff.error_code;
   assign rsp_state_now        = rsp_res_ff.state_next;

   `MLCC_ASSERT_NEXT(a_err_keeps_state, clock, reset, fire && (step_res.error_code != ERR_OK), $stable(state_ff))
   `MLCC_ASSERT_SAME(a_rsp_matches_state, clock, reset, rsp_valid_ff, rsp_res_ff.state_next == state_ff)
   `MLCC_ASSERT_SAME(a_miss_has_request, clock, reset, rsp_valid_ff && rsp_res_ff.miss, rsp_res_ff.bus_request != REQ_NONE)
   `MLCC_ASSERT_SAME(a_stall_needs_both, clock, reset, req_stall, in_valid_ff && rsp_valid_ff && rsp_stall)

endmodule
